// ===== hdl/lsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the least-squares line fit unit.
// Depends on nothing; every other file of the block imports it.
package lsf_pkg;

    // Default and largest run length; record widths are sized for the largest.
    localparam int MAX_POINTS_DEF = 128;
    localparam int MAX_POINTS_HI  = 4096;
    localparam int HI_LOG_W       = $clog2(MAX_POINTS_HI);

    localparam int RUN_CNT_W = $clog2(MAX_POINTS_HI + 1);
    localparam int RUN_SX_W  = 24 + HI_LOG_W;
    localparam int RUN_SXX_W = 47 + HI_LOG_W;
    localparam int RUN_SXY_W = 48 + HI_LOG_W;

    // Width of the arithmetic in the back end, and the limit for the radicand.
    localparam int WIDE_W     = 128;
    localparam int SQ_LIM_BIT = 62;

    typedef enum logic [1:0] {
        FIT_OK   = 2'd0,
        FIT_FEW  = 2'd1,
        FIT_NO_X = 2'd2,
        FIT_NO_Y = 2'd3
    } t_fit_status;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [23:0] start_x;
        logic signed [23:0] end_x;
        logic signed [15:0] correlation;
        t_fit_status        fit_status;
    } t_fit;

    // One finished run, handed from the front end to the back end.
    typedef struct packed {
        logic        [RUN_CNT_W-1:0] count;
        logic signed [RUN_SX_W-1:0]  sum_x;
        logic signed [RUN_SX_W-1:0]  sum_y;
        logic        [RUN_SXX_W-1:0] sum_xx;
        logic        [RUN_SXX_W-1:0] sum_yy;
        logic signed [RUN_SXY_W-1:0] sum_xy;
        logic signed [23:0]          first_x;
        logic signed [23:0]          end_x;
    } t_run;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MUL,
        ST_ACC,
        ST_EVAL,
        ST_DLOAD,
        ST_DIV,
        ST_DFIN,
        ST_SHIFT,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_SLOPE,
        DIV_ICPT,
        DIV_CORR
    } t_div_sel;

    typedef struct packed {
        logic pop;
        logic out_load;
        logic mul_last;
        logic div_last;
        logic sqrt_last;
        logic need_shift;
    } t_back_ctl;

endpackage

// ===== hdl/least_squares_line_fit_unit.sv =====
`timescale 1ns / 1ps
// Top level of the least-squares line fit unit: front end, run queue, back end.
// Uses lsf_pkg, lsf_front, lsf_queue and lsf_back.

// Points of a run arrive one per request on the input channel and are taken
// at one per cycle: the front end folds each into exact integer sums of x, y,
// x*x, y*y and x*y, with a count and the first x. A request with last_point
// set closes the run; its sums go into a two-entry queue and the front end is
// at once ready for the next run. The back end takes runs from the queue one
// at a time and works them out with one shared 64 by 8 bit multiplier (nine
// products), a one-bit-a-cycle restoring divider of 128 steps (used for
// slope, intercept and correlation) and a bit-serial square root of 64
// steps. Runs with fewer than two points or no x spread finish without the
// divisions and the square root. The input stalls only when two closed
// runs are already waiting for the back end. Results leave through an output
// register, so the back end can start the next run while a result is held.
// Points beyond MAX_POINTS in one run are dropped from the sums; the last x
// is still reported.
module least_squares_line_fit_unit
    import lsf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_point i_point,
    input  logic   i_valid,
    output logic   o_stall,
    output t_fit   o_fit,
    output logic   o_valid,
    input  logic   i_stall
);

    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_run push_run;
    t_run head_run;

    // Accumulates points and closes runs.
    lsf_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .i_valid (i_valid),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_run   (push_run)
    );

    // Decouples the point stream from the slow fit arithmetic.
    lsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (push_run),
        .i_pop   (q_pop),
        .o_run   (head_run),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Computes the fit of one run at a time.
    lsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (head_run),
        .i_run_valid (!q_empty),
        .o_pop       (q_pop),
        .o_fit       (o_fit),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

`ifndef SYNTHESIS
    // A closed run must never be pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("run pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("run popped from an empty queue");

    // Runs with fewer than two points carry a zero fit.
    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fit.fit_status == FIT_FEW) |->
            (o_fit.slope == '0 && o_fit.intercept == '0 && o_fit.correlation == '0))
        else $error("degenerate run gave a non-zero fit");

    // With no y spread the correlation is reported as zero.
    a_no_y_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fit.fit_status == FIT_NO_Y) |-> o_fit.correlation == '0)
        else $error("flat run gave a non-zero correlation");
`endif

endmodule

// ===== hdl/lsf_front.sv =====
`timescale 1ns / 1ps
// Front end: accumulates the exact sums of a run, one point per cycle unless the queue is full.
// Uses lsf_pkg; pushes each finished run into lsf_queue.
module lsf_front
    import lsf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_point i_point,
    input  logic   i_valid,
    input  logic   i_full,
    output logic   o_stall,
    output logic   o_push,
    output t_run   o_run
);

    localparam int LW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = 24 + LW;
    localparam int SXXW = 47 + LW;
    localparam int SXYW = 48 + LW;

    logic        [CW-1:0]   r_count, n_count;
    logic signed [SXW-1:0]  r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic        [SXXW-1:0] r_sum_xx, n_sum_xx, r_sum_yy, n_sum_yy;
    logic signed [SXYW-1:0] r_sum_xy, n_sum_xy;
    logic signed [23:0]     r_first, n_first;
    logic signed [47:0]     prod_xx, prod_yy, prod_xy;
    logic                   take;
    logic                   accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && i_point.last_point;

    assign take    = r_count < CW'(MAX_POINTS);
    assign prod_xx = i_point.point_x * i_point.point_x;
    assign prod_yy = i_point.point_y * i_point.point_y;
    assign prod_xy = i_point.point_x * i_point.point_y;

    always_comb begin
        n_count  = r_count;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_sum_xx = r_sum_xx;
        n_sum_yy = r_sum_yy;
        n_sum_xy = r_sum_xy;
        n_first  = r_first;
        if (take) begin
            n_count  = r_count + CW'(1);
            n_sum_x  = r_sum_x + SXW'(i_point.point_x);
            n_sum_y  = r_sum_y + SXW'(i_point.point_y);
            n_sum_xx = r_sum_xx + SXXW'(prod_xx[46:0]);
            n_sum_yy = r_sum_yy + SXXW'(prod_yy[46:0]);
            n_sum_xy = r_sum_xy + SXYW'(prod_xy);
            if (r_count == '0) begin
                n_first = i_point.point_x;
            end
        end
    end

    always_comb begin
        o_run.count   = RUN_CNT_W'(n_count);
        o_run.sum_x   = RUN_SX_W'(n_sum_x);
        o_run.sum_y   = RUN_SX_W'(n_sum_y);
        o_run.sum_xx  = RUN_SXX_W'(n_sum_xx);
        o_run.sum_yy  = RUN_SXX_W'(n_sum_yy);
        o_run.sum_xy  = RUN_SXY_W'(n_sum_xy);
        o_run.first_x = n_first;
        o_run.end_x   = i_point.point_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_yy <= '0;
            r_sum_xy <= '0;
            r_first  <= '0;
        end else if (accept) begin
            if (i_point.last_point) begin
                r_count  <= '0;
                r_sum_x  <= '0;
                r_sum_y  <= '0;
                r_sum_xx <= '0;
                r_sum_yy <= '0;
                r_sum_xy <= '0;
                r_first  <= '0;
            end else begin
                r_count  <= n_count;
                r_sum_x  <= n_sum_x;
                r_sum_y  <= n_sum_y;
                r_sum_xx <= n_sum_xx;
                r_sum_yy <= n_sum_yy;
                r_sum_xy <= n_sum_xy;
                r_first  <= n_first;
            end
        end
    end

endmodule

// ===== hdl/lsf_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of finished runs between the front and the back end.
// Uses lsf_pkg for the run record.
module lsf_queue
    import lsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    input  logic i_pop,
    output t_run o_run,
    output logic o_empty,
    output logic o_full
);

    t_run       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_run   = r_mem[r_rptr];
    assign o_empty = r_fill == 2'd0;
    assign o_full  = r_fill == 2'd2;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/lsf_back.sv =====
`timescale 1ns / 1ps
// Back end: forms the centred sums, slope, intercept and correlation of a run
// with a shared digit-serial multiplier, a restoring divider and a bit-serial
// square root. Uses lsf_pkg; takes runs from lsf_queue.
module lsf_back
    import lsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_run i_run,
    input  logic i_run_valid,
    output logic o_pop,
    output t_fit o_fit,
    output logic o_valid,
    input  logic i_stall
);

    localparam int W   = WIDE_W;
    localparam int DCW = $clog2(W);

    t_state   r_state, n_state;
    t_back_ctl ctl;
    t_run     r_rec;
    logic [3:0] r_pidx;

    // Multiplier
    logic [63:0]  r_ma, r_mb;
    logic [W-1:0] r_macc;
    logic         r_mneg;
    logic [2:0]   r_mcnt;
    logic signed [64:0] op_a, op_b, neg_a, neg_b;
    logic [63:0]  mag_a, mag_b;
    logic [71:0]  m_part;
    logic signed [W-1:0] acc_val;

    // Centred sums
    logic signed [W-1:0] r_sxx, r_syy, r_sxy, r_bnum;
    logic         r_cneg;

    // Divider
    t_div_sel     r_dsel;
    logic [W-1:0] r_drem, r_dq, r_dden;
    logic         r_dneg;
    logic [DCW-1:0] r_dcnt;
    logic [W:0]   d_rsh;
    logic         d_ge;
    logic [W:0]   d_rnew;
    logic [W-1:0] d_num, d_den;
    logic         d_neg;
    logic [32:0]  d_hi, d_lim, d_v, d_res;

    // Square root
    logic [W-1:0] r_rad;
    logic [63:0]  r_root;
    logic [65:0]  r_srem;
    logic [5:0]   r_scnt;
    logic [67:0]  s_rsh, s_trial;
    logic         s_ge;

    // Results
    logic signed [31:0] r_slope, r_icpt;
    logic signed [15:0] r_corr;
    t_fit_status r_status;
    logic        r_ovalid;
    t_fit        r_out;

    assign o_pop   = ctl.pop;
    assign o_fit   = r_out;
    assign o_valid = r_ovalid;

    // Operand selection for the eight products and the radicand product.
    always_comb begin
        case (r_pidx)
            4'd0: begin op_a = 65'(r_rec.count); op_b = 65'(r_rec.sum_xx); end
            4'd1: begin op_a = 65'(r_rec.sum_x);  op_b = 65'(r_rec.sum_x);  end
            4'd2: begin op_a = 65'(r_rec.count); op_b = 65'(r_rec.sum_yy); end
            4'd3: begin op_a = 65'(r_rec.sum_y);  op_b = 65'(r_rec.sum_y);  end
            4'd4: begin op_a = 65'(r_rec.count); op_b = 65'(r_rec.sum_xy); end
            4'd5: begin op_a = 65'(r_rec.sum_x);  op_b = 65'(r_rec.sum_y);  end
            4'd6: begin op_a = 65'(r_rec.sum_xx); op_b = 65'(r_rec.sum_y);  end
            4'd7: begin op_a = 65'(r_rec.sum_x);  op_b = 65'(r_rec.sum_xy); end
            default: begin
                op_a = {1'b0, r_sxx[63:0]};
                op_b = {1'b0, r_syy[63:0]};
            end
        endcase
        neg_a = -op_a;
        neg_b = -op_b;
        mag_a = op_a[64] ? neg_a[63:0] : op_a[63:0];
        mag_b = op_b[64] ? neg_b[63:0] : op_b[63:0];
    end

    assign m_part  = r_ma * r_mb[63:56];
    assign acc_val = r_mneg ? -$signed(r_macc) : $signed(r_macc);

    // Divider step and operand selection.
    assign d_rsh  = {r_drem, r_dq[W-1]};
    assign d_ge   = d_rsh >= {1'b0, r_dden};
    assign d_rnew = d_ge ? d_rsh - {1'b0, r_dden} : d_rsh;

    always_comb begin
        d_den = r_sxx;
        case (r_dsel)
            DIV_SLOPE: begin
                d_num = {r_sxy[W-17:0], 16'b0};
                d_neg = r_cneg;
            end
            DIV_ICPT: begin
                d_num = r_bnum[W-1] ? W'(-r_bnum) : W'(r_bnum);
                d_neg = r_bnum[W-1];
            end
            DIV_CORR: begin
                d_num = {r_sxy[W-16:0], 15'b0};
                d_neg = r_cneg;
                d_den = W'(r_root);
            end
            default: begin
                d_num = '0;
                d_neg = 1'b0;
            end
        endcase
    end

    // Truncated quotient, saturated to the field's signed range.
    always_comb begin
        d_hi  = (r_dsel == DIV_CORR) ? 33'h0_0000_7FFF : 33'h0_7FFF_FFFF;
        d_lim = r_dneg ? d_hi + 33'd1 : d_hi;
        d_v   = (r_dq[W-1:32] != '0 || 33'(r_dq[31:0]) > d_lim) ? d_lim : 33'(r_dq[31:0]);
        d_res = r_dneg ? -d_v : d_v;
    end

    // Square root step: two radicand bits in, one root bit out.
    assign s_rsh   = {r_srem, r_rad[W-1:W-2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    assign s_ge    = s_rsh >= s_trial;

    // Control outputs.
    always_comb begin
        ctl.pop        = (r_state == ST_IDLE) && i_run_valid;
        ctl.out_load   = (r_state == ST_DONE) && (!r_ovalid || !i_stall);
        ctl.mul_last   = r_mcnt == 3'd7;
        ctl.div_last   = r_dcnt == DCW'(W - 1);
        ctl.sqrt_last  = r_scnt == 6'd63;
        ctl.need_shift = (r_sxx[W-1:SQ_LIM_BIT] != '0) || (r_syy[W-1:SQ_LIM_BIT] != '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (ctl.pop) n_state = ST_MLOAD;
            end
            ST_MLOAD: n_state = ST_MUL;
            ST_MUL: begin
                if (ctl.mul_last) n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_pidx == 4'd8) begin
                    n_state = ST_SQRT;
                end else if (r_pidx == 4'd7) begin
                    n_state = ST_EVAL;
                end else begin
                    n_state = ST_MLOAD;
                end
            end
            ST_EVAL: begin
                if (r_rec.count < RUN_CNT_W'(2) || r_sxx == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                if (r_dsel == DIV_CORR && r_root == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (ctl.div_last) n_state = ST_DFIN;
            end
            ST_DFIN: begin
                case (r_dsel)
                    DIV_SLOPE: n_state = ST_DLOAD;
                    DIV_ICPT:  n_state = (r_syy == '0) ? ST_DONE : ST_SHIFT;
                    default:   n_state = ST_DONE;
                endcase
            end
            ST_SHIFT: begin
                if (!ctl.need_shift) n_state = ST_MLOAD;
            end
            ST_SQRT: begin
                if (ctl.sqrt_last) n_state = ST_DLOAD;
            end
            ST_DONE: begin
                if (ctl.out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (ctl.pop) begin
                    r_rec    <= i_run;
                    r_pidx   <= 4'd0;
                    r_sxx    <= '0;
                    r_syy    <= '0;
                    r_sxy    <= '0;
                    r_bnum   <= '0;
                    r_slope  <= '0;
                    r_icpt   <= '0;
                    r_corr   <= '0;
                    r_status <= FIT_OK;
                    r_root   <= '0;
                end
            end
            ST_MLOAD: begin
                r_ma   <= mag_a;
                r_mb   <= mag_b;
                r_mneg <= op_a[64] ^ op_b[64];
                r_macc <= '0;
                r_mcnt <= 3'd0;
            end
            ST_MUL: begin
                r_macc <= {r_macc[W-9:0], 8'b0} + W'(m_part);
                r_mb   <= {r_mb[55:0], 8'b0};
                r_mcnt <= r_mcnt + 3'd1;
            end
            ST_ACC: begin
                case (r_pidx)
                    4'd0: r_sxx  <= r_sxx + acc_val;
                    4'd1: r_sxx  <= r_sxx - acc_val;
                    4'd2: r_syy  <= r_syy + acc_val;
                    4'd3: r_syy  <= r_syy - acc_val;
                    4'd4: r_sxy  <= r_sxy + acc_val;
                    4'd5: r_sxy  <= r_sxy - acc_val;
                    4'd6: r_bnum <= r_bnum + acc_val;
                    4'd7: r_bnum <= r_bnum - acc_val;
                    default: begin
                        r_rad  <= r_macc;
                        r_srem <= '0;
                        r_root <= '0;
                        r_scnt <= 6'd0;
                    end
                endcase
                if (r_pidx != 4'd8) begin
                    r_pidx <= r_pidx + 4'd1;
                end
            end
            ST_EVAL: begin
                r_cneg <= r_sxy[W-1];
                r_sxy  <= r_sxy[W-1] ? -r_sxy : r_sxy;
                r_dsel <= DIV_SLOPE;
                if (r_rec.count < RUN_CNT_W'(2)) begin
                    r_status <= FIT_FEW;
                end else if (r_sxx == '0) begin
                    r_status <= FIT_NO_X;
                end
            end
            ST_DLOAD: begin
                r_drem <= '0;
                r_dq   <= d_num;
                r_dden <= d_den;
                r_dneg <= d_neg;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                r_drem <= d_rnew[W-1:0];
                r_dq   <= {r_dq[W-2:0], d_ge};
                r_dcnt <= r_dcnt + DCW'(1);
            end
            ST_DFIN: begin
                case (r_dsel)
                    DIV_SLOPE: begin
                        r_slope <= d_res[31:0];
                        r_dsel  <= DIV_ICPT;
                    end
                    DIV_ICPT: begin
                        r_icpt <= d_res[31:0];
                        r_dsel <= DIV_CORR;
                        if (r_syy == '0) begin
                            r_status <= FIT_NO_Y;
                        end
                    end
                    default: r_corr <= d_res[15:0];
                endcase
            end
            ST_SHIFT: begin
                if (ctl.need_shift) begin
                    r_sxx <= r_sxx >>> 1;
                    r_syy <= r_syy >>> 1;
                    r_sxy <= r_sxy >>> 1;
                end
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[W-3:0], 2'b00};
                r_srem <= s_ge ? 66'(s_rsh - s_trial) : s_rsh[65:0];
                r_root <= {r_root[62:0], s_ge};
                r_scnt <= r_scnt + 6'd1;
            end
            ST_DONE: begin
                if (ctl.out_load) begin
                    r_out.slope       <= r_slope;
                    r_out.intercept   <= r_icpt;
                    r_out.start_x     <= r_rec.first_x;
                    r_out.end_x       <= r_rec.end_x;
                    r_out.correlation <= r_corr;
                    r_out.fit_status  <= r_status;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sim/tb_least_squares_line_fit_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the least-squares line fit unit: directed and random runs of points,
// with every fit checked against a predictor kept in step with each request.
// Depends on lsf_pkg and least_squares_line_fit_unit.
module tb_least_squares_line_fit_unit;
    import lsf_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam int RUN_LIMIT = 128;
    localparam int IDLE_LIMIT = 30000;
    localparam int RANDOM_ITEMS = 1700;

    // Keeps the running sums of the current run and the queue of fits still owed.
    class fit_scoreboard;
        int        mismatches;
        int        point_count;
        longint    sum_x, sum_y, sum_xy, sum_xx, sum_yy;
        logic [23:0] first_x;
        t_fit      owed_fits[$];

        function new();
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            point_count = 0;
            sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; sum_yy = 0;
            first_x = '0;
        endfunction

        // Truncating quotient of num * 2^sh by a positive den, saturated to [-(hi+1), hi].
        function longint sat_quot(wide_t num, wide_t den, int sh, longint hi);
            wide_t mag, q, lim;
            bit    neg;
            neg = num < 0;
            mag = neg ? -num : num;
            q = (mag <<< sh) / den;
            lim = neg ? hi + 1 : hi;
            if (q > lim) q = lim;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void note_point(t_point p);
            longint x, y;
            wide_t  n, sx, sy, dxx, dyy, dxy, bnum, a, b, c, prod, root, trial, one;
            t_fit   f;
            x = p.point_x;
            y = p.point_y;
            if (point_count < RUN_LIMIT) begin
                if (point_count == 0) first_x = p.point_x;
                point_count++;
                sum_x += x;
                sum_y += y;
                sum_xx += x * x;
                sum_yy += y * y;
                sum_xy += x * y;
            end
            if (!p.last_point) return;

            n = point_count;
            sx = sum_x;
            sy = sum_y;
            a = sum_xx;
            b = sum_yy;
            c = sum_xy;
            dxx = n * a - sx * sx;
            dyy = n * b - sy * sy;
            dxy = n * c - sx * sy;

            f = '0;
            f.start_x = first_x;
            f.end_x = p.point_x;
            if (point_count < 2) begin
                f.fit_status = FIT_FEW;
            end else if (dxx == 0) begin
                f.fit_status = FIT_NO_X;
            end else begin
                bnum = a * sy - sx * c;
                f.slope = 32'(sat_quot(dxy, dxx, 16, 64'h7FFF_FFFF));
                f.intercept = 32'(sat_quot(bnum, dxx, 0, 64'h7FFF_FFFF));
                if (dyy == 0) begin
                    f.fit_status = FIT_NO_Y;
                end else begin
                    f.fit_status = FIT_OK;
                    // Scale both spreads down together until the radicand fits.
                    a = dxx;
                    b = dyy;
                    c = dxy < 0 ? -dxy : dxy;
                    while (a >= (wide_t'(1) <<< 62) || b >= (wide_t'(1) <<< 62)) begin
                        a = a >>> 1;
                        b = b >>> 1;
                        c = c >>> 1;
                    end
                    prod = a * b;
                    root = 0;
                    one = 1;
                    for (int k = 63; k >= 0; k--) begin
                        trial = root | (one <<< k);
                        if (trial * trial <= prod) root = trial;
                    end
                    if (root != 0)
                        f.correlation = 16'(sat_quot(dxy < 0 ? -c : c, root, 15, 64'h7FFF));
                end
            end
            owed_fits = {owed_fits, f};
            clear_run();
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("fit mismatch on %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_fit(t_fit got);
            t_fit want;
            if (owed_fits.size() == 0) begin
                report_mismatch("unexpected fit, start_x", got.start_x, 0);
                return;
            end
            want = owed_fits.pop_front();
            if (got.slope !== want.slope) report_mismatch("slope", got.slope, want.slope);
            if (got.intercept !== want.intercept)
                report_mismatch("intercept", got.intercept, want.intercept);
            if (got.start_x !== want.start_x)
                report_mismatch("start_x", got.start_x, want.start_x);
            if (got.end_x !== want.end_x) report_mismatch("end_x", got.end_x, want.end_x);
            if (got.correlation !== want.correlation)
                report_mismatch("correlation", got.correlation, want.correlation);
            if (got.fit_status !== want.fit_status)
                report_mismatch("fit_status", got.fit_status, want.fit_status);
        endtask
    endclass

    logic   i_clk;
    logic   i_rst_n;
    t_point i_point;
    logic   i_valid;
    logic   o_stall;
    t_fit   o_fit;
    logic   o_valid;
    logic   i_stall;

    fit_scoreboard fits = new();
    bit quiet;        // no idling on either side in the closing part
    int idle_cycles = 0;
    int stall_burst;

    least_squares_line_fit_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_fit   (o_fit),
        .o_valid (o_valid),
        .i_stall (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The result side stalls in random bursts until the closing part of the run.
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
            stall_burst <= 0;
        end else if (stall_burst > 0) begin
            i_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if ($urandom_range(7) == 0) begin
            i_stall <= 1'b1;
            stall_burst <= $urandom_range(17);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every result request taken is checked against the oldest fit still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) fits.check_fit(o_fit);
    end

    // The watchdog counts cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one point, after an occasional idle burst, and holds it until taken.
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, logic last);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.last_point = last;
        if (!quiet && $urandom_range(9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= p;
        do @(posedge i_clk); while (o_stall);
        fits.note_point(p);
    endtask

    function automatic logic signed [23:0] pick_coord();
        case ($urandom_range(5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'($urandom_range(64) - 32);
            3: return 24'($urandom_range(4000) - 2000);
            default: return 24'($urandom);
        endcase
    endfunction

    // One run of len points. Shapes: random cloud, noisy line, constant x, constant y.
    task automatic send_run(int len, int shape);
        logic signed [23:0] x, y, x0, y0;
        int slope_num, noise;
        x0 = pick_coord();
        y0 = pick_coord();
        slope_num = $urandom_range(64) - 32;
        noise = $urandom_range(3) == 0 ? 0 : $urandom_range(300);
        for (int k = 0; k < len; k++) begin
            x = pick_coord();
            y = pick_coord();
            case (shape)
                1: begin
                    x = 24'((int'($urandom_range(2000)) - 1000) * 16);
                    y = 24'(int'(x) * slope_num / 8 + int'(y0) / 4
                            + int'($urandom_range(noise)));
                end
                2: x = x0;
                3: y = y0;
                default: ;
            endcase
            send_point(x, y, k == len - 1);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (fits.owed_fits.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int sent, len;
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_point <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone point, no x spread, no y spread, the field extremes.
        send_point(24'sh000100, 24'sh000200, 1'b1);
        send_point(24'sh000010, 24'sh000001, 1'b0);
        send_point(24'sh000010, 24'sh000400, 1'b1);
        send_point(-24'sd5, 24'sh000033, 1'b0);
        send_point(24'sd77, 24'sh000033, 1'b0);
        send_point(24'sd9, 24'sh000033, 1'b1);
        send_point(24'sh800000, 24'sh800000, 1'b0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
        send_point(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_point(24'sh7FFFFF, 24'sh800000, 1'b1);
        // Steep line so that the slope saturates in both directions.
        send_point(24'sd0, 24'sh800000, 1'b0);
        send_point(24'sd1, 24'sh7FFFFF, 1'b1);
        send_point(24'sd0, 24'sh7FFFFF, 1'b0);
        send_point(24'sd1, 24'sh800000, 1'b1);
        send_point(24'sd3, -24'sd2, 1'b0);
        send_point(24'sd4, 24'sd2, 1'b0);
        send_point(24'sd5, 24'sd1, 1'b1);

        // The sender holds off until every owed fit has come back.
        wait_drained();

        // Runs longer than the point limit, where the excess is left out of the sums.
        send_run(RUN_LIMIT + 5, 0);
        send_run(RUN_LIMIT + 1, 1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - sent < 200) quiet = 1'b1;
            len = $urandom_range(40) == 0 ? $urandom_range(100, 140) : $urandom_range(1, 10);
            send_run(len, $urandom_range(4) > 3 ? $urandom_range(2, 3) : $urandom_range(1));
            sent += len;
        end

        wait_drained();
        repeat (700) @(posedge i_clk);
        if (fits.mismatches == 0 && fits.owed_fits.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
